// ----- sv/bpca_pkg.sv -----
// shared types and constants for the cached buffer allocator
package bpca_pkg;

  localparam int NUM_BUFS    = 1024;
  localparam int BUF_W       = 10;
  localparam int FILL_W      = 11;
  localparam int THREADS     = 4;
  localparam int THR_W       = 2;
  localparam int CACHE_DEPTH = 64;
  localparam int CIDX_W      = 6;
  localparam int CFILL_W     = 7;
  localparam int MAX_SEGS    = 16;
  localparam int NSEG_W      = 5;
  localparam int POS_W       = 4;
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 3;

  localparam logic [1:0] CMD_ALLOC     = 2'd0;
  localparam logic [1:0] CMD_FREE      = 2'd1;
  localparam logic [1:0] CMD_PRECHARGE = 2'd2;
  localparam logic [1:0] CMD_FLUSH     = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_BUFS   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_DATA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_ROOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_ROOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH     = 3'd6;

  typedef struct packed {
    logic [15:0] seg_data_bytes;
    logic [9:0]  head_room;
    logic [9:0]  tail_room;
    logic        single_segment_only;
    logic [16:0] max_total_len;
    logic [4:0]  cache_keep;
    logic [5:0]  cache_flush;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [THR_W-1:0]  thread;
    logic [BUF_W-1:0]  buffer_index;
    logic              too_large;
    logic [NSEG_W-1:0] nsegs;
  } job_t;

endpackage

// ----- sv/bpca_req_if.sv -----
// request channel interface
interface bpca_req_if import bpca_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  thread;
  logic [15:0] request_size;
  logic [9:0]  buffer_index;

  modport source (output valid, cmd, thread, request_size, buffer_index, input ready);
  modport sink (input valid, cmd, thread, request_size, buffer_index, output ready);
endinterface

// ----- sv/bpca_rsp_if.sv -----
// result channel interface
interface bpca_rsp_if import bpca_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] segment;
  logic [3:0] seg_position;
  logic [4:0] seg_total;
  logic [5:0] refilled;
  logic [10:0] ring_count;
  logic [6:0] thread_cache_count;
  logic       last;

  modport source (output valid, status, segment, seg_position, seg_total, refilled,
                  ring_count, thread_cache_count, last, input ready);
  modport sink (input valid, status, segment, seg_position, seg_total, refilled,
                ring_count, thread_cache_count, last, output ready);
endinterface

// ----- sv/bpca_front.sv -----
// front end: accepts requests, sizes allocations, classifies jobs
module bpca_front import bpca_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  bpca_req_if.sink req,
  output logic   q_push,
  output job_t   q_din,
  input  logic   q_full
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_DIV  = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  logic [1:0]  state;
  job_t        job;
  logic [16:0] rem;
  logic [16:0] total;
  logic        big;

  always_comb begin
    total = (req.request_size == 16'd0) ? 17'd0 :
            17'(cfg.head_room) + 17'(req.request_size) + 17'(cfg.tail_room);
    big = cfg.single_segment_only ? (total > {1'b0, cfg.seg_data_bytes})
                                  : (total > cfg.max_total_len);
  end

  assign req.ready = (state == FS_IDLE);
  assign q_push    = (state == FS_PUSH) && !q_full;
  assign q_din     = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      case (state)
        FS_IDLE: begin
          if (req.valid) begin
            if (req.cmd == CMD_ALLOC && !big && total != 17'd0 &&
                cfg.seg_data_bytes != 16'd0) begin
              state <= FS_DIV;
            end else begin
              state <= FS_PUSH;
            end
          end
        end
        FS_DIV: begin
          // one segment subtracted per cycle, stops at the segment limit
          if (rem <= {1'b0, cfg.seg_data_bytes} || job.nsegs == NSEG_W'(MAX_SEGS)) begin
            state <= FS_PUSH;
          end
        end
        FS_PUSH: begin
          if (!q_full) state <= FS_IDLE;
        end
        default: state <= FS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      FS_IDLE: begin
        if (req.valid) begin
          job.cmd          <= req.cmd;
          job.thread       <= req.thread;
          job.buffer_index <= req.buffer_index;
          job.too_large    <= (req.cmd == CMD_ALLOC) && big;
          job.nsegs        <= NSEG_W'(1);
          rem              <= total;
        end
      end
      FS_DIV: begin
        if (rem > {1'b0, cfg.seg_data_bytes}) begin
          rem <= rem - {1'b0, cfg.seg_data_bytes};
          if (job.nsegs == NSEG_W'(MAX_SEGS)) begin
            job.too_large <= 1'b1;
          end else begin
            job.nsegs <= job.nsegs + NSEG_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/bpca_queue.sv -----
// two-entry job queue between front and back end
module bpca_queue import bpca_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= din;
  end

endmodule

// ----- sv/bpca_back.sv -----
// back end: ring, thread caches, chain links and the job sequencer
module bpca_back import bpca_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_empty,
  input  job_t q_dout,
  output logic q_pop,
  bpca_rsp_if.source rsp
);

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_A_CHK   = 5'd3;
  localparam logic [4:0] S_A_CHK2  = 5'd4;
  localparam logic [4:0] S_A_RD    = 5'd5;
  localparam logic [4:0] S_A_USE   = 5'd6;
  localparam logic [4:0] S_RF_RD   = 5'd7;
  localparam logic [4:0] S_RF_WR   = 5'd8;
  localparam logic [4:0] S_F_LEN   = 5'd9;
  localparam logic [4:0] S_W_PUT   = 5'd10;
  localparam logic [4:0] S_W_NXT   = 5'd11;
  localparam logic [4:0] S_SP_RD   = 5'd12;
  localparam logic [4:0] S_SP_WR   = 5'd13;
  localparam logic [4:0] S_FA      = 5'd14;
  localparam logic [4:0] S_FA_NEXT = 5'd15;
  localparam logic [4:0] S_RES     = 5'd16;

  localparam int CADDR_W = THR_W + CIDX_W;

  // storage
  logic [BUF_W-1:0]  ring   [NUM_BUFS];
  logic [BUF_W-1:0]  cstore [THREADS*CACHE_DEPTH];
  logic [BUF_W-1:0]  link   [NUM_BUFS];
  logic [NSEG_W-1:0] clen   [NUM_BUFS];
  logic [BUF_W-1:0]  ring_rd, c_rd, link_rd;
  logic [NSEG_W-1:0] clen_rd;

  logic              ring_we, c_we, link_we, clen_we;
  logic [BUF_W-1:0]  ring_wa, ring_wd, link_wa, link_wd, clen_wa;
  logic [CADDR_W-1:0] c_wa, c_ra;
  logic [BUF_W-1:0]  c_wd;
  logic [NSEG_W-1:0] clen_wd;

  // control state
  logic [4:0]         state, ret;
  logic [BUF_W-1:0]   init_cnt;
  logic [BUF_W-1:0]   head;
  logic [FILL_W-1:0]  fill;
  logic [CFILL_W-1:0] cf [THREADS];
  logic               ovalid;

  // job state
  logic [1:0]         cmd;
  logic [THR_W-1:0]   t;
  logic [BUF_W-1:0]   idx, cur, prev;
  logic               too_large;
  logic [NSEG_W-1:0]  n, walk_i;
  logic [POS_W-1:0]   pos;
  logic [CIDX_W-1:0]  base;
  logic               src_cache;
  logic [1:0]         status;
  logic [5:0]         refilled;
  logic [CFILL_W-1:0] cnt, sp_i, sp_end;

  // result register
  logic [1:0]  o_status;
  logic [9:0]  o_segment;
  logic [3:0]  o_pos;
  logic [4:0]  o_total;
  logic [5:0]  o_refilled;
  logic [10:0] o_ring;
  logic [6:0]  o_tcc;
  logic        o_last;

  logic [CFILL_W-1:0] cf_t, fl, need, target, keepv;
  logic [BUF_W-1:0]   seg, put_addr;
  logic               put_ok, out_free, to_ring, seg_last, o_load;

  always_comb begin
    cf_t     = cf[t];
    fl       = (CFILL_W'(cfg.cache_flush) < CFILL_W'(CACHE_DEPTH)) ?
               CFILL_W'(cfg.cache_flush) : CFILL_W'(CACHE_DEPTH);
    need     = fl - cf_t;
    target   = CFILL_W'(n) + CFILL_W'(cfg.cache_keep);
    if (target > CFILL_W'(CACHE_DEPTH)) target = CFILL_W'(CACHE_DEPTH);
    keepv    = (CFILL_W'(cfg.cache_keep) < cf_t) ? CFILL_W'(cfg.cache_keep) : cf_t;
    seg      = src_cache ? c_rd : ring_rd;
    put_addr = BUF_W'(FILL_W'(head) + fill);
    put_ok   = fill < FILL_W'(NUM_BUFS);
    out_free = !ovalid || rsp.ready;
    o_load   = out_free && ((state == S_A_USE) || (state == S_RES));
    to_ring  = (n > cfg.cache_keep) || (cf_t >= CFILL_W'(CACHE_DEPTH));
    seg_last = (NSEG_W'(pos) == n - NSEG_W'(1));
    q_pop    = (state == S_IDLE) && !q_empty;
    // spill sweeps read by sweep index, allocations by chain position
    if (state == S_SP_RD || state == S_SP_WR) begin
      c_ra = {t, sp_i[CIDX_W-1:0]};
    end else begin
      c_ra = {t, CIDX_W'(base + CIDX_W'(pos))};
    end
  end

  always_comb begin
    ring_we = 1'b0; ring_wa = put_addr; ring_wd = cur;
    c_we    = 1'b0; c_wa = {t, cf_t[CIDX_W-1:0]}; c_wd = cur;
    link_we = 1'b0; link_wa = prev; link_wd = seg;
    clen_we = 1'b0; clen_wa = seg; clen_wd = n;
    case (state)
      S_INIT: begin
        ring_we = 1'b1; ring_wa = init_cnt; ring_wd = init_cnt;
        clen_we = 1'b1; clen_wa = init_cnt; clen_wd = NSEG_W'(1);
      end
      S_RF_WR: begin
        c_we = 1'b1; c_wd = ring_rd;
      end
      S_A_USE: begin
        if (out_free) begin
          if (pos != '0) link_we = 1'b1;
          else clen_we = 1'b1;
        end
      end
      S_W_PUT: begin
        if (to_ring) ring_we = put_ok;
        else c_we = 1'b1;
      end
      S_SP_WR: begin
        ring_we = put_ok; ring_wd = c_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring[ring_wa] <= ring_wd;
    ring_rd <= ring[head];
  end

  always_ff @(posedge clk) begin
    if (c_we) cstore[c_wa] <= c_wd;
    c_rd <= cstore[c_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link[link_wa] <= link_wd;
    link_rd <= link[cur];
  end

  always_ff @(posedge clk) begin
    if (clen_we) clen[clen_wa] <= clen_wd;
    clen_rd <= clen[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_cnt <= '0;
      head     <= '0;
      fill     <= FILL_W'(NUM_BUFS);
      for (int i = 0; i < THREADS; i++) cf[i] <= '0;
      ovalid   <= 1'b0;
    end else begin
      ovalid <= o_load || (ovalid && !rsp.ready);
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + BUF_W'(1);
          if (init_cnt == BUF_W'(NUM_BUFS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd       <= q_dout.cmd;
            t         <= q_dout.thread;
            idx       <= q_dout.buffer_index;
            cur       <= q_dout.buffer_index;
            too_large <= q_dout.too_large;
            n         <= q_dout.nsegs;
            state     <= S_DISP;
          end
        end
        S_DISP: begin
          case (cmd)
            CMD_ALLOC: begin
              refilled <= '0;
              if (too_large) begin
                status <= ST_TOO_LARGE;
                state  <= S_RES;
              end else begin
                status <= ST_OK;
                state  <= S_A_CHK;
              end
            end
            CMD_FREE: begin
              status   <= ST_OK;
              refilled <= '0;
              state    <= S_F_LEN;
            end
            CMD_PRECHARGE: begin
              status <= ST_OK;
              if (!(cf_t >= CFILL_W'(cfg.cache_keep) || fl <= cf_t) &&
                  fill >= FILL_W'(need)) begin
                refilled <= need[5:0];
                cnt      <= need;
                ret      <= S_RES;
                state    <= S_RF_RD;
              end else begin
                refilled <= '0;
                state    <= S_RES;
              end
            end
            default: begin
              status   <= ST_OK;
              refilled <= '0;
              t        <= '0;
              state    <= S_FA;
            end
          endcase
        end
        S_A_CHK: begin
          if (n <= cfg.cache_keep && cf_t < CFILL_W'(n) &&
              fill >= FILL_W'(target - cf_t)) begin
            cnt   <= target - cf_t;
            ret   <= S_A_CHK2;
            state <= S_RF_RD;
          end else begin
            state <= S_A_CHK2;
          end
        end
        S_A_CHK2: begin
          pos <= '0;
          if (n <= cfg.cache_keep && cf_t >= CFILL_W'(n)) begin
            src_cache <= 1'b1;
            base      <= CIDX_W'(cf_t - CFILL_W'(n));
            cf[t]     <= cf_t - CFILL_W'(n);
            state     <= S_A_RD;
          end else if (fill < FILL_W'(n)) begin
            status <= ST_NO_BUFS;
            state  <= S_RES;
          end else begin
            src_cache <= 1'b0;
            fill      <= fill - FILL_W'(n);
            state     <= S_A_RD;
          end
        end
        S_A_RD: state <= S_A_USE;
        S_A_USE: begin
          if (out_free) begin
            o_status   <= ST_OK;
            o_segment  <= seg;
            o_pos      <= pos;
            o_total    <= n;
            o_refilled <= '0;
            o_ring     <= fill;
            o_tcc      <= cf_t;
            o_last     <= seg_last;
            prev       <= seg;
            if (!src_cache) head <= head + BUF_W'(1);
            if (seg_last) begin
              state <= S_IDLE;
            end else begin
              pos   <= pos + POS_W'(1);
              state <= S_A_RD;
            end
          end
        end
        S_RF_RD: state <= S_RF_WR;
        S_RF_WR: begin
          cf[t] <= cf_t + CFILL_W'(1);
          head  <= head + BUF_W'(1);
          fill  <= fill - FILL_W'(1);
          cnt   <= cnt - CFILL_W'(1);
          state <= (cnt == CFILL_W'(1)) ? ret : S_RF_RD;
        end
        S_F_LEN: begin
          walk_i <= '0;
          if (clen_rd == '0) n <= NSEG_W'(1);
          else if (clen_rd > NSEG_W'(MAX_SEGS)) n <= NSEG_W'(MAX_SEGS);
          else n <= clen_rd;
          // cache over the flush level spills down to the keep level first
          if (cf_t > CFILL_W'(cfg.cache_flush)) begin
            cf[t] <= keepv;
            if (keepv < cf_t) begin
              sp_i   <= keepv;
              sp_end <= cf_t;
              ret    <= S_W_PUT;
              state  <= S_SP_RD;
            end else begin
              state <= S_W_PUT;
            end
          end else begin
            state <= S_W_PUT;
          end
        end
        S_W_PUT: begin
          if (to_ring) begin
            if (put_ok) fill <= fill + FILL_W'(1);
          end else begin
            cf[t] <= cf_t + CFILL_W'(1);
          end
          if (walk_i == n - NSEG_W'(1)) begin
            state <= S_RES;
          end else begin
            walk_i <= walk_i + NSEG_W'(1);
            state  <= S_W_NXT;
          end
        end
        S_W_NXT: begin
          cur   <= link_rd;
          state <= S_W_PUT;
        end
        S_SP_RD: state <= S_SP_WR;
        S_SP_WR: begin
          if (put_ok) fill <= fill + FILL_W'(1);
          sp_i  <= sp_i + CFILL_W'(1);
          state <= (sp_i + CFILL_W'(1) == sp_end) ? ret : S_SP_RD;
        end
        S_FA: begin
          if (cf_t != '0) begin
            sp_i   <= '0;
            sp_end <= cf_t;
            cf[t]  <= '0;
            ret    <= S_FA_NEXT;
            state  <= S_SP_RD;
          end else begin
            state <= S_FA_NEXT;
          end
        end
        S_FA_NEXT: begin
          if (t == THR_W'(THREADS - 1)) begin
            state <= S_RES;
          end else begin
            t     <= t + THR_W'(1);
            state <= S_FA;
          end
        end
        S_RES: begin
          if (out_free) begin
            o_status   <= status;
            o_segment  <= '0;
            o_pos      <= '0;
            o_total    <= '0;
            o_refilled <= refilled;
            o_ring     <= fill;
            o_tcc      <= cf_t;
            o_last     <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid              = ovalid;
  assign rsp.status             = o_status;
  assign rsp.segment            = o_segment;
  assign rsp.seg_position       = o_pos;
  assign rsp.seg_total          = o_total;
  assign rsp.refilled           = o_refilled;
  assign rsp.ring_count         = o_ring;
  assign rsp.thread_cache_count = o_tcc;
  assign rsp.last               = o_last;

endmodule

// ----- sv/buffer_pool_cached_allocator_core.sv -----
// alloc: sizing in the front, then a cache refill entry by entry and one result per segment
// free: spills cache entries over the flush level, then puts back the chain segment by segment
// precharge: moves ring entries into the cache one at a time; flush all: spills every cached entry
// one job in the back end at a time, the front sizes the next one meanwhile
// reset is synchronous; the back end then loads all 1024 entries of the free ring
// and chain lengths before it takes a job (config writes are taken throughout)
module buffer_pool_cached_allocator_core import bpca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bpca_req_if.sink             req,
  bpca_rsp_if.source           rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_din, q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seg_data_bytes      <= 16'd2048;
      cfg.head_room           <= 10'd128;
      cfg.tail_room           <= 10'd0;
      cfg.single_segment_only <= 1'b0;
      cfg.max_total_len       <= 17'd65535;
      cfg.cache_keep          <= 5'd8;
      cfg.cache_flush         <= 6'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEG_DATA:  cfg.seg_data_bytes      <= cfg_data[15:0];
        REG_HEAD_ROOM: cfg.head_room           <= cfg_data[9:0];
        REG_TAIL_ROOM: cfg.tail_room           <= cfg_data[9:0];
        REG_SINGLE:    cfg.single_segment_only <= cfg_data[0];
        REG_MAX_TOTAL: cfg.max_total_len       <= cfg_data[16:0];
        REG_KEEP:      cfg.cache_keep          <= cfg_data[4:0];
        REG_FLUSH:     cfg.cache_flush         <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  bpca_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .req    (req),
    .q_push (q_push),
    .q_din  (q_din),
    .q_full (q_full)
  );

  bpca_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  bpca_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_dout  (q_dout),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

// ----- tb/bpca_pool_checker.sv -----
// pool behavior predictor and result checker for the cached buffer allocator
`timescale 1ns / 1ps
module bpca_pool_checker import bpca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bpca_req_if                  req,
  bpca_rsp_if                  rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fails,
  output int                   outstanding
);

  typedef struct packed {
    logic [1:0]         status;
    logic [BUF_W-1:0]   segment;
    logic [POS_W-1:0]   seg_position;
    logic [NSEG_W-1:0]  seg_total;
    logic [5:0]         refilled;
    logic [FILL_W-1:0]  ring_count;
    logic [CFILL_W-1:0] thread_cache_count;
    logic               last;
  } seg_result_t;

  logic [BUF_W-1:0] ring [NUM_BUFS];
  int               ring_head;
  int               ring_fill;
  logic [BUF_W-1:0] cache [THREADS][CACHE_DEPTH];
  int               cache_fill [THREADS];
  logic [BUF_W-1:0] link [NUM_BUFS];
  int               chain_len [NUM_BUFS];
  cfg_t             cfg;
  seg_result_t      pool_results [$];

  function automatic void reset_pool();
    for (int i = 0; i < NUM_BUFS; i++) begin
      ring[i] = BUF_W'(i);
      link[i] = '0;
      chain_len[i] = 1;
    end
    for (int t = 0; t < THREADS; t++) cache_fill[t] = 0;
    ring_head = 0;
    ring_fill = NUM_BUFS;
    cfg.seg_data_bytes = 16'd2048;
    cfg.head_room = 10'd128;
    cfg.tail_room = '0;
    cfg.single_segment_only = 1'b0;
    cfg.max_total_len = 17'd65535;
    cfg.cache_keep = 5'd8;
    cfg.cache_flush = 6'd12;
    pool_results.delete();
  endfunction

  // a full ring drops the index (double free)
  function automatic void ring_put(int v);
    if (ring_fill >= NUM_BUFS) return;
    ring[(ring_head + ring_fill) % NUM_BUFS] = BUF_W'(v);
    ring_fill++;
  endfunction

  function automatic int ring_take();
    int v;
    v = ring[ring_head];
    ring_head = (ring_head + 1) % NUM_BUFS;
    ring_fill--;
    return v;
  endfunction

  function automatic void post(int t, logic [1:0] st, int seg, int pos, int tot, int refl,
                               bit lst);
    seg_result_t r;
    r.status = st;
    r.segment = BUF_W'(seg);
    r.seg_position = POS_W'(pos);
    r.seg_total = NSEG_W'(tot);
    r.refilled = 6'(refl);
    r.ring_count = FILL_W'(ring_fill);
    r.thread_cache_count = CFILL_W'(cache_fill[t]);
    r.last = lst;
    pool_results.push_back(r);
  endfunction

  function automatic void refill_cache(int t, int cnt);
    for (int i = 0; i < cnt; i++) begin
      cache[t][cache_fill[t]] = BUF_W'(ring_take());
      cache_fill[t]++;
    end
  endfunction

  function automatic void predict_alloc(int t, int size);
    int total, nsegs, fill, target, keep, seg;
    int bufs [MAX_SEGS];
    bit got, big;
    keep = cfg.cache_keep;
    seg = cfg.seg_data_bytes;
    total = (size != 0) ? int'(cfg.head_room) + size + int'(cfg.tail_room) : 0;
    big = cfg.single_segment_only ? (total > seg) : (total > int'(cfg.max_total_len));
    if (big) begin
      post(t, ST_TOO_LARGE, 0, 0, 0, 0, 1);
      return;
    end
    nsegs = (total == 0 || seg == 0) ? 1 : (total + seg - 1) / seg;
    if (nsegs > MAX_SEGS) begin
      post(t, ST_TOO_LARGE, 0, 0, 0, 0, 1);
      return;
    end
    got = 0;
    if (nsegs <= keep) begin
      fill = cache_fill[t];
      if (fill < nsegs) begin
        target = nsegs + keep;
        if (target > CACHE_DEPTH) target = CACHE_DEPTH;
        // a refill the ring cannot cover moves nothing
        if (target >= nsegs && ring_fill >= target - fill) refill_cache(t, target - fill);
        fill = cache_fill[t];
      end
      if (fill >= nsegs) begin
        for (int i = 0; i < nsegs; i++) bufs[i] = cache[t][fill - nsegs + i];
        cache_fill[t] = fill - nsegs;
        got = 1;
      end
    end
    if (!got) begin
      if (ring_fill < nsegs) begin
        post(t, ST_NO_BUFS, 0, 0, 0, 0, 1);
        return;
      end
      for (int i = 0; i < nsegs; i++) bufs[i] = ring_take();
    end
    for (int i = 0; i + 1 < nsegs; i++) link[bufs[i]] = BUF_W'(bufs[i + 1]);
    chain_len[bufs[0]] = nsegs;
    for (int i = 0; i < nsegs; i++) post(t, ST_OK, bufs[i], i, nsegs, 0, i + 1 == nsegs);
  endfunction

  function automatic void predict_free(int t, int head);
    int n, cur, fill, keep;
    int segs [MAX_SEGS];
    n = chain_len[head];
    if (n == 0) n = 1;
    if (n > MAX_SEGS) n = MAX_SEGS;
    segs[0] = head;
    cur = head;
    for (int i = 1; i < n; i++) begin
      segs[i] = link[cur];
      cur = link[cur];
    end
    fill = cache_fill[t];
    if (fill > cfg.cache_flush) begin
      keep = (cfg.cache_keep < fill) ? cfg.cache_keep : fill;
      for (int i = keep; i < fill; i++) ring_put(cache[t][i]);
      cache_fill[t] = keep;
    end
    if (n > cfg.cache_keep) begin
      for (int i = 0; i < n; i++) ring_put(segs[i]);
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (cache_fill[t] >= CACHE_DEPTH) begin
        ring_put(segs[i]);
      end else begin
        cache[t][cache_fill[t]] = BUF_W'(segs[i]);
        cache_fill[t]++;
      end
    end
  endfunction

  function automatic int predict_precharge(int t);
    int fill, fl, need;
    fill = cache_fill[t];
    fl = (cfg.cache_flush < CACHE_DEPTH) ? cfg.cache_flush : CACHE_DEPTH;
    if (fill >= cfg.cache_keep || fl <= fill) return 0;
    need = fl - fill;
    if (ring_fill < need) return 0;
    refill_cache(t, need);
    return need;
  endfunction

  function automatic void predict_flush_all();
    for (int t = 0; t < THREADS; t++) begin
      for (int i = 0; i < cache_fill[t]; i++) ring_put(cache[t][i]);
      cache_fill[t] = 0;
    end
  endfunction

  initial begin
    fails = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    seg_result_t seen, want;
    int t;
    if (rst) begin
      reset_pool();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEG_DATA:  cfg.seg_data_bytes = cfg_data[15:0];
          REG_HEAD_ROOM: cfg.head_room = cfg_data[9:0];
          REG_TAIL_ROOM: cfg.tail_room = cfg_data[9:0];
          REG_SINGLE:    cfg.single_segment_only = cfg_data[0];
          REG_MAX_TOTAL: cfg.max_total_len = cfg_data[16:0];
          REG_KEEP:      cfg.cache_keep = cfg_data[4:0];
          REG_FLUSH:     cfg.cache_flush = cfg_data[5:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        seen = '{rsp.status, rsp.segment, rsp.seg_position, rsp.seg_total, rsp.refilled,
                 rsp.ring_count, rsp.thread_cache_count, rsp.last};
        if (pool_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat %p", $time, seen);
        end else begin
          want = pool_results.pop_front();
          if (seen !== want) begin
            fails++;
            $display("%0t: result mismatch expected %p actual %p", $time, want, seen);
          end
        end
      end
      if (req.valid && req.ready) begin
        t = req.thread % THREADS;
        case (req.cmd)
          CMD_ALLOC: predict_alloc(t, req.request_size);
          CMD_FREE: begin
            predict_free(t, req.buffer_index);
            post(t, ST_OK, 0, 0, 0, 0, 1);
          end
          CMD_PRECHARGE: post(t, ST_OK, 0, 0, 0, predict_precharge(t), 1);
          default: begin
            predict_flush_all();
            post(t, ST_OK, 0, 0, 0, 0, 1);
          end
        endcase
      end
    end
    outstanding = pool_results.size();
  end

endmodule

// ----- tb/tb_buffer_pool_cached_allocator_core.sv -----
// stimulus and verdict for the cached buffer allocator
`timescale 1ns / 1ps
module tb_buffer_pool_cached_allocator_core;
  import bpca_pkg::*;

  localparam int RUN_LIMIT = 600000;
  localparam int SETTLE = 600;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fails;
  int                   outstanding;
  int                   cycles;
  int                   send_idle_pct;
  int                   stall_pct;
  bit                   hold_req;

  // view of the chains seen on the result channel, used to pick safe frees
  int               known_len [NUM_BUFS];
  logic [BUF_W-1:0] known_link [NUM_BUFS];
  bit               link_set [NUM_BUFS];
  bit               in_use [NUM_BUFS];
  int               live_heads [$];
  int               chain_head;
  int               prev_seg;
  bit               dup_freed;

  bpca_req_if req ();
  bpca_rsp_if rsp ();

  buffer_pool_cached_allocator_core DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bpca_pool_checker pool_chk (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.seg_total != 0) begin
      if (rsp.seg_position == 0) begin
        known_len[rsp.segment] = rsp.seg_total;
        chain_head = rsp.segment;
      end else begin
        known_link[prev_seg] = rsp.segment;
        link_set[prev_seg] = 1;
      end
      prev_seg = rsp.segment;
      in_use[rsp.segment] = 1;
      if (rsp.last) live_heads.push_back(chain_head);
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    rsp.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        rsp.ready <= 0;
        repeat (400) @(posedge clk);
      end
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic bit chain_safe(int h);
    int n, cur;
    n = known_len[h];
    if (n < 1) n = 1;
    if (n > MAX_SEGS) n = MAX_SEGS;
    cur = h;
    for (int i = 1; i < n; i++) begin
      if (!link_set[cur]) return 0;
      cur = known_link[cur];
    end
    return 1;
  endfunction

  function automatic void release_chain(int h);
    int n, cur;
    n = known_len[h];
    if (n < 1) n = 1;
    if (n > MAX_SEGS) n = MAX_SEGS;
    cur = h;
    for (int i = 0; i < n; i++) begin
      in_use[cur] = 0;
      cur = known_link[cur];
    end
  endfunction

  task automatic send(logic [1:0] cmd, int thr, int size, int idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.cmd <= cmd;
    req.thread <= THR_W'(thr);
    req.request_size <= 16'(size);
    req.buffer_index <= BUF_W'(idx);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic quiesce();
    req.valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
  endtask

  task automatic apply_cfg(int seg, int head, int tail, int single, int maxl, int keep,
                           int flush);
    write_reg(REG_SEG_DATA, seg);
    write_reg(REG_HEAD_ROOM, head);
    write_reg(REG_TAIL_ROOM, tail);
    write_reg(REG_SINGLE, single);
    write_reg(REG_MAX_TOTAL, maxl);
    write_reg(REG_KEEP, keep);
    write_reg(REG_FLUSH, flush);
    cfg_we <= 0;
  endtask

  task automatic free_live(int thr);
    int k, h;
    k = $urandom_range(live_heads.size() - 1);
    h = live_heads[k];
    live_heads.delete(k);
    // once duplicates exist, chains may be rewritten: only free from a settled state
    if (dup_freed) quiesce();
    if (!chain_safe(h)) begin
      send(CMD_PRECHARGE, thr, $urandom_range(65535), $urandom_range(1023));
      return;
    end
    release_chain(h);
    send(CMD_FREE, thr, $urandom_range(65535), h);
  endtask

  task automatic free_all_live();
    while (live_heads.size() > 0) free_live($urandom_range(THREADS - 1));
  endtask

  task automatic stray_frees(int count);
    int h;
    quiesce();
    for (int i = 0; i < count; i++) begin
      h = $urandom_range(NUM_BUFS - 1);
      if (!in_use[h] && chain_safe(h)) begin
        dup_freed = 1;
        send(CMD_FREE, $urandom_range(THREADS - 1), $urandom_range(65535), h);
      end
    end
  endtask

  task automatic random_items(int count, int alloc_pct, int free_pct, int size_max);
    int r, thr, size;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      thr = $urandom_range(THREADS - 1);
      if (r < alloc_pct) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(size_max);
        send(CMD_ALLOC, thr, size, $urandom_range(1023));
      end else if (r < alloc_pct + free_pct && live_heads.size() > 0) begin
        free_live(thr);
      end else if (r < 94) begin
        send(CMD_PRECHARGE, thr, $urandom_range(65535), $urandom_range(1023));
      end else begin
        send(CMD_FLUSH, thr, $urandom_range(65535), $urandom_range(1023));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_BUFS; i++) begin
      known_len[i] = 1;
      link_set[i] = 0;
      in_use[i] = 0;
    end
    cycles = 0;
    dup_freed = 0;
    hold_req = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 0;
    req.cmd = CMD_ALLOC;
    req.thread = '0;
    req.request_size = '0;
    req.buffer_index = '0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: default sizing, edge sizes, all commands
    apply_cfg(2048, 128, 0, 0, 65535, 8, 12);
    send(CMD_ALLOC, 0, 0, 0);
    send(CMD_ALLOC, 1, 65535, 1023);
    send(CMD_ALLOC, 2, 32640, 0);
    send(CMD_ALLOC, 3, 32641, 0);
    send(CMD_ALLOC, 3, 100, 0);
    send(CMD_ALLOC, 1, 5000, 0);
    send(CMD_PRECHARGE, 0, 0, 0);
    send(CMD_PRECHARGE, 3, 0, 0);
    send(CMD_FLUSH, 2, 0, 0);
    send(CMD_ALLOC, 0, 20000, 0);
    quiesce();
    free_all_live();
    send(CMD_PRECHARGE, 2, 0, 0);
    send(CMD_PRECHARGE, 2, 0, 0);
    send(CMD_FLUSH, 1, 0, 0);
    random_items(25, 45, 35, 6000);
    quiesce();

    // one segment per request, equal keep and flush levels, sender mostly idle
    apply_cfg(0, 0, 1023, 0, 67583, 1, 1);
    send_idle_pct = 78;
    random_items(25, 45, 35, 65535);
    quiesce();

    // small segments, deep cache; receiver stalls and one long hold-off
    apply_cfg(64, 0, 0, 0, 1024, 16, 32);
    send_idle_pct = 0;
    stall_pct = 78;
    hold_req = 1;
    random_items(20, 60, 25, 700);
    // run the pool dry
    for (int i = 0; i < 70; i++) send(CMD_ALLOC, $urandom_range(THREADS - 1), 1000, 0);
    quiesce();
    free_all_live();
    send(CMD_FLUSH, 0, 0, 0);
    quiesce();

    // single segment mode, flush level below keep
    apply_cfg(65535, 0, 0, 1, 1, 4, 2);
    send_idle_pct = 24;
    stall_pct = 24;
    random_items(25, 45, 35, 65535);
    quiesce();

    // tiny total limit
    apply_cfg(2048, 1023, 1023, 0, 1, 8, 12);
    send_idle_pct = 0;
    stall_pct = 0;
    random_items(8, 70, 20, 300);
    quiesce();

    // double frees and ring overflow
    apply_cfg(512, 5, 7, 0, 8192, 8, 12);
    random_items(15, 45, 35, 3000);
    stray_frees(8);
    send(CMD_FLUSH, 1, 0, 0);
    random_items(15, 45, 35, 3000);
    free_all_live();
    send(CMD_FLUSH, 3, 0, 0);
    quiesce();

    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- buffer_pool_cached_allocator_core.f -----
sv/bpca_pkg.sv
sv/bpca_req_if.sv
sv/bpca_rsp_if.sv
sv/bpca_front.sv
sv/bpca_queue.sv
sv/bpca_back.sv
sv/buffer_pool_cached_allocator_core.sv
tb/bpca_pool_checker.sv
tb/tb_buffer_pool_cached_allocator_core.sv
